// ----- hw/rtl/matrix_multiply_4x4_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply block
// Short forms for clocked implication checks with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_4X4_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMUL_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define MMUL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/mmul_pkg.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared constants and the control beat that runs down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package mmul_pkg;

	localparam int DIM_DEF       = 4;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int PROD_W        = 2 * DATA_W;

	// Control that travels alongside each partial sum.
	typedef struct packed {
		logic valid;
		logic last;
	} ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mmul_cell.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply cell
// Holds one left column and one right row, multiplies one pair per beat and
// adds the term to the partial sum handed in by the previous cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mmul_cell #(
	parameter int DIM       = mmul_pkg::DIM_DEF,
	parameter int FRAC_BITS = mmul_pkg::FRAC_BITS_DEF,
	parameter int CELL_IDX  = 0,
	localparam int ROW_W    = $clog2(DIM),
	localparam int IDX_W    = $clog2(DIM * DIM),
	localparam int ACC_W    = mmul_pkg::PROD_W - FRAC_BITS + $clog2(DIM)
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 wr_en,
	input  wire  [IDX_W-1:0]                    wr_idx,
	input  wire  [mmul_pkg::DATA_W-1:0]         wr_lhs,
	input  wire  [mmul_pkg::DATA_W-1:0]         wr_rhs,
	input  wire  mmul_pkg::ctrl_t               ctrl_in,
	input  wire  [ROW_W-1:0]                    row_in,
	input  wire  [ROW_W-1:0]                    col_in,
	input  wire  signed [ACC_W-1:0]             acc_in,
	output mmul_pkg::ctrl_t                     ctrl_out,
	output logic [ROW_W-1:0]                    row_out,
	output logic [ROW_W-1:0]                    col_out,
	output logic signed [ACC_W-1:0]             acc_out
);

	localparam int TERM_W = mmul_pkg::PROD_W - FRAC_BITS;

	// Column CELL_IDX of the left matrix and row CELL_IDX of the right one.
	logic [mmul_pkg::DATA_W-1:0] lcol_q [DIM];
	logic [mmul_pkg::DATA_W-1:0] rrow_q [DIM];

	logic signed [mmul_pkg::DATA_W-1:0] op_a;
	logic signed [mmul_pkg::DATA_W-1:0] op_b;
	logic signed [mmul_pkg::PROD_W-1:0] prod;

	mmul_pkg::ctrl_t                    ctrl_s1;
	logic [ROW_W-1:0]                   row_s1;
	logic [ROW_W-1:0]                   col_s1;
	logic signed [ACC_W-1:0]            acc_s1;
	logic signed [mmul_pkg::PROD_W-1:0] prod_s1;
	logic signed [TERM_W-1:0]           term;

	mmul_pkg::ctrl_t                    ctrl_s2;
	logic [ROW_W-1:0]                   row_s2;
	logic [ROW_W-1:0]                   col_s2;
	logic signed [ACC_W-1:0]            acc_s2;

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIM; k++) begin
			if (wr_en && wr_idx == IDX_W'(k * DIM + CELL_IDX)) begin
				lcol_q[k] <= wr_lhs;
			end
			if (wr_en && wr_idx == IDX_W'(CELL_IDX * DIM + k)) begin
				rrow_q[k] <= wr_rhs;
			end
		end
	end

	assign op_a = $signed(lcol_q[row_in]);
	assign op_b = $signed(rrow_q[col_in]);
	assign prod = op_a * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else begin
			ctrl_s1 <= ctrl_in;
			ctrl_s2 <= ctrl_s1;
		end
	end

	// The arithmetic shift rounds each term toward minus infinity.
	assign term = $signed(prod_s1[mmul_pkg::PROD_W-1:FRAC_BITS]);

	always_ff @(posedge clk) begin
		row_s1  <= row_in;
		col_s1  <= col_in;
		acc_s1  <= acc_in;
		prod_s1 <= prod;
		row_s2  <= row_s1;
		col_s2  <= col_s1;
		acc_s2  <= acc_s1 + ACC_W'(term);
	end

	assign ctrl_out = ctrl_s2;
	assign row_out  = row_s2;
	assign col_out  = col_s2;
	assign acc_out  = acc_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/mmul_sat.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply output stage
// Clamps the finished sum to 32 bits and registers the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mmul_sat #(
	parameter int DIM       = mmul_pkg::DIM_DEF,
	parameter int FRAC_BITS = mmul_pkg::FRAC_BITS_DEF,
	localparam int ROW_W    = $clog2(DIM),
	localparam int IDX_W    = $clog2(DIM * DIM),
	localparam int ACC_W    = mmul_pkg::PROD_W - FRAC_BITS + $clog2(DIM)
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  mmul_pkg::ctrl_t               ctrl_in,
	input  wire  [ROW_W-1:0]                    row_in,
	input  wire  [ROW_W-1:0]                    col_in,
	input  wire  signed [ACC_W-1:0]             acc_in,
	output logic                                result_valid,
	output logic signed [mmul_pkg::DATA_W-1:0]  product_element,
	output logic [IDX_W-1:0]                    product_index,
	output logic                                last_of_matrix
);

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(32'sh8000_0000);

	logic signed [mmul_pkg::DATA_W-1:0] clamped;
	logic        [IDX_W-1:0]            flat_idx;

	always_comb begin
		if (acc_in > SAT_HI) begin
			clamped = 32'sh7FFF_FFFF;
		end else if (acc_in < SAT_LO) begin
			clamped = 32'sh8000_0000;
		end else begin
			clamped = acc_in[mmul_pkg::DATA_W-1:0];
		end
	end

	assign flat_idx = IDX_W'(IDX_W'(row_in) * IDX_W'(DIM) + IDX_W'(col_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= ctrl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		product_element <= clamped;
		product_index   <= flat_idx;
		last_of_matrix  <= ctrl_in.last;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/matrix_multiply_4x4.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply, DIM x DIM, signed fixed point
// Loads two matrices element by element and streams out their product.
// ----------------------------------------------------------------------------
// Each beat on start writes one left element and one right element at the
// row-major position element_index; positions at or above DIM*DIM are taken
// and ignored. A beat that carries the last position (DIM*DIM-1) also starts
// the product: DIM*DIM results leave in row-major order on consecutive
// cycles, each shown for exactly one cycle with result_valid high, and the
// final one flagged by last_of_matrix. The receiver cannot stall, so it must
// take every result beat in the cycle it appears. Loading beats may follow
// back to back while busy is low. After the triggering beat busy stays high
// until the last sum leaves the cell chain, and start is honored again in the
// cycle that shows the last result. The sequencer issues one output
// position a cycle into a chain of DIM cells, each two registers deep
// (multiply, then shift and add), followed by the saturation register.
// ----------------------------------------------------------------------------
// Cell k holds column k of the left matrix and row k of the right matrix. A
// beat for position (r, c) enters cell 0 with a zero sum; cell k adds
// L[r][k] * R[k][c], shifted right by FRAC_BITS, and hands the sum on. The
// sum leaves the last cell complete and is clamped to the signed 32-bit
// range. The stores keep their contents across products, so a partial
// rewrite mixes new and old entries. Reading an entry that was never written
// gives an undefined element.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_multiply_4x4_assert.svh"

module matrix_multiply_4x4 #(
	parameter int DIM       = mmul_pkg::DIM_DEF,
	parameter int FRAC_BITS = mmul_pkg::FRAC_BITS_DEF,
	localparam int ROW_W    = $clog2(DIM),
	localparam int IDX_W    = $clog2(DIM * DIM),
	localparam int ACC_W    = mmul_pkg::PROD_W - FRAC_BITS + $clog2(DIM)
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  [IDX_W-1:0]                    element_index,
	input  wire  signed [mmul_pkg::DATA_W-1:0]  lhs_element,
	input  wire  signed [mmul_pkg::DATA_W-1:0]  rhs_element,
	output logic                                result_valid,
	output logic signed [mmul_pkg::DATA_W-1:0]  product_element,
	output logic [IDX_W-1:0]                    product_index,
	output logic                                last_of_matrix
);

	localparam int CELLS = DIM * DIM;

	logic accept;
	logic trigger;

	// Sequencer state: busy from trigger until the last sum leaves the chain, run while issuing.
	logic             busy_q;
	logic             run_q;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] col_q;
	logic             issue_last;

	// Chain links; link 0 is the sequencer, link DIM feeds the output stage.
	mmul_pkg::ctrl_t         ctrl_c [DIM+1];
	logic [ROW_W-1:0]        row_c  [DIM+1];
	logic [ROW_W-1:0]        col_c  [DIM+1];
	logic signed [ACC_W-1:0] acc_c  [DIM+1];

	assign accept  = start && !busy_q;
	assign trigger = accept && (element_index == IDX_W'(CELLS - 1));
	assign busy    = busy_q;

	assign issue_last = (row_q == ROW_W'(DIM - 1)) && (col_q == ROW_W'(DIM - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			run_q  <= 1'b0;
			row_q  <= '0;
			col_q  <= '0;
		end else begin
			if (trigger) begin
				busy_q <= 1'b1;
				run_q  <= 1'b1;
				row_q  <= '0;
				col_q  <= '0;
			end else begin
				// The last sum leaves the chain: the stores are free again.
				if (ctrl_c[DIM].valid && ctrl_c[DIM].last) begin
					busy_q <= 1'b0;
				end
				if (run_q) begin
					if (issue_last) begin
						run_q <= 1'b0;
					end
					if (col_q == ROW_W'(DIM - 1)) begin
						col_q <= '0;
						row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + ROW_W'(1);
					end
				end
			end
		end
	end

	assign ctrl_c[0].valid = run_q;
	assign ctrl_c[0].last  = run_q && issue_last;
	assign row_c[0]        = row_q;
	assign col_c[0]        = col_q;
	assign acc_c[0]        = '0;

	for (genvar k = 0; k < DIM; k++) begin : g_cell
		mmul_cell #(
			.DIM       (DIM),
			.FRAC_BITS (FRAC_BITS),
			.CELL_IDX  (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (accept),
			.wr_idx   (element_index),
			.wr_lhs   (lhs_element),
			.wr_rhs   (rhs_element),
			.ctrl_in  (ctrl_c[k]),
			.row_in   (row_c[k]),
			.col_in   (col_c[k]),
			.acc_in   (acc_c[k]),
			.ctrl_out (ctrl_c[k+1]),
			.row_out  (row_c[k+1]),
			.col_out  (col_c[k+1]),
			.acc_out  (acc_c[k+1])
		);
	end

	mmul_sat #(
		.DIM       (DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_sat (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl_in         (ctrl_c[DIM]),
		.row_in          (row_c[DIM]),
		.col_in          (col_c[DIM]),
		.acc_in          (acc_c[DIM]),
		.result_valid    (result_valid),
		.product_element (product_element),
		.product_index   (product_index),
		.last_of_matrix  (last_of_matrix)
	);

	// Issuing only ever happens inside a busy window.
	`MMUL_ASSERT_SAME(a_run_in_busy, clk, arst_n, run_q, busy_q)
	// A trigger opens a busy window with the sequencer running.
	`MMUL_ASSERT_NEXT(a_trigger_runs, clk, arst_n, trigger, busy_q && run_q)
	// Results of one product come in an unbroken burst.
	`MMUL_ASSERT_NEXT(a_burst, clk, arst_n, result_valid && !last_of_matrix, result_valid)
	// The flagged result is the final position of the matrix.
	`MMUL_ASSERT_SAME(a_last_index, clk, arst_n, result_valid && last_of_matrix,
		product_index == IDX_W'(CELLS - 1))

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for matrix_multiply_4x4
// Loads left and right Q16.16 matrices one beat at a time, computes every
// product element in its own fixed-point model, and checks each result beat
// field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DIM          = mmul_pkg::DIM_DEF;
	localparam int FRAC_BITS    = mmul_pkg::FRAC_BITS_DEF;
	localparam int CELLS        = DIM * DIM;
	localparam int IDX_W        = $clog2(CELLS);
	localparam int RANDOM_BEATS = 360;
	// This margin covers anything still in the cell chain after the last result.
	localparam int DRAIN_CYCLES = 4 * DIM + 8;
	// The slowest correct run is roughly 400 beats with their idle gaps and
	// busy windows. Allow far more than that.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SMALL_SPAN   = 4 << FRAC_BITS;

	typedef logic signed [mmul_pkg::DATA_W-1:0] element_t;

	localparam element_t Q_MAX = 32'sh7fff_ffff;
	localparam element_t Q_MIN = 32'sh8000_0000;
	localparam element_t Q_ONE = element_t'(1 << FRAC_BITS);

	// The last row-major position both stores a pair and starts the product.
	localparam logic [IDX_W-1:0] TRIGGER_POS = IDX_W'(CELLS - 1);

	// One product element as it should appear on the result ports.
	typedef struct {
		element_t         element;
		logic [IDX_W-1:0] index;
		logic             last;
	} product_beat_t;

	logic             clk;
	logic             arst_n        = 1'b0;
	logic             start         = 1'b0;
	logic [IDX_W-1:0] element_index = '0;
	element_t         lhs_element   = '0;
	element_t         rhs_element   = '0;
	wire              busy;
	wire              result_valid;
	wire  element_t   product_element;
	wire  [IDX_W-1:0] product_index;
	wire              last_of_matrix;

	// The testbench's own copy of both matrix stores.
	element_t      lhs_mem [CELLS];
	element_t      rhs_mem [CELLS];
	product_beat_t expected_products [$];

	int mismatch_count = 0;
	int beats_sent     = 0;
	int cycle_count    = 0;
	// Largest idle gap that the sender may insert before a beat; zero gives
	// back-to-back stretches.
	int max_gap        = 0;
	// When set, random elements may also be full-range or extreme values,
	// which push most dot products into saturation.
	bit wide_values    = 1'b0;

	matrix_multiply_4x4 #(
		.DIM       (DIM),
		.FRAC_BITS (FRAC_BITS)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.element_index   (element_index),
		.lhs_element     (lhs_element),
		.rhs_element     (rhs_element),
		.result_valid    (result_valid),
		.product_element (product_element),
		.product_index   (product_index),
		.last_of_matrix  (last_of_matrix)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Dot product of a left row and a right column. Every term is formed
	// exactly in 64 bits and shifted arithmetically, so it rounds toward minus
	// infinity; only the full sum is clamped to the 32-bit range.
	function automatic element_t dot_product_at(int row, int col);
		longint total;
		total = 0;
		for (int k = 0; k < DIM; k++)
			total += (longint'(lhs_mem[row * DIM + k]) * longint'(rhs_mem[k * DIM + col]))
				>>> FRAC_BITS;
		if (total > longint'(Q_MAX))
			return Q_MAX;
		if (total < longint'(Q_MIN))
			return Q_MIN;
		return element_t'(total);
	endfunction

	// Random element. Most values are a few units in Q16.16 so that sums stay
	// in range and the exact arithmetic is visible; tiny values exercise the
	// rounding of the fraction shift.
	function automatic element_t random_element();
		case ($urandom_range(0, wide_values ? 9 : 7))
			5:       return element_t'($urandom) >>> 9;
			6, 7:    return element_t'($urandom_range(0, 32)) - 16;
			8:       return element_t'($urandom);
			9: begin
				case ($urandom_range(0, 5))
					0:       return Q_MAX;
					1:       return Q_MIN;
					2:       return '0;
					3:       return -1;
					4:       return Q_ONE;
					default: return -Q_ONE;
				endcase
			end
			default: return element_t'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
		endcase
	endfunction

	// Sends one beat and updates the model once the block takes it.
	// Start is only lowered when an idle gap comes first, so a gap of zero
	// keeps it high across consecutive beats without a glitch in one step.
	task automatic send_element_pair(input logic [IDX_W-1:0] idx, input element_t lhs,
		input element_t rhs);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		element_index <= idx;
		lhs_element   <= lhs;
		rhs_element   <= rhs;
		// Busy is read before this edge's updates land, so the beat is taken
		// at the first edge where it was low.
		do @(posedge clk); while (busy);
		beats_sent++;
		lhs_mem[idx] = lhs;
		rhs_mem[idx] = rhs;
		if (idx == TRIGGER_POS) begin
			for (int r = 0; r < DIM; r++)
				for (int c = 0; c < DIM; c++)
					expected_products.push_back('{dot_product_at(r, c), IDX_W'(r * DIM + c),
						(r == DIM - 1) && (c == DIM - 1)});
		end
	endtask

	// Drops start, waits for every predicted element, then lets the cell
	// chain run empty.
	task automatic settle_products();
		start <= 1'b0;
		while (expected_products.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Full load with no idle cycles. The left matrix is the identity except
	// for a maximal corner, the right matrix holds extremes and small values:
	// row 0 saturates high, row 1 lands exactly on the most negative value,
	// and rows 2 and 3 pass the right matrix through unchanged.
	task automatic test_identity_with_extremes();
		element_t rhs_plan [CELLS] = '{
			Q_MAX, Q_MAX, Q_MAX, Q_MAX,
			Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			-1, 1, Q_ONE - 1, -Q_ONE,
			Q_ONE / 2, -3, 32'sh0000_ffff, 7
		};
		element_t lhs_value;
		max_gap = 0;
		for (int p = 0; p < CELLS; p++) begin
			if (p == 0)
				lhs_value = Q_MAX;
			else if (p % (DIM + 1) == 0)
				lhs_value = Q_ONE;
			else
				lhs_value = '0;
			send_element_pair(IDX_W'(p), lhs_value, rhs_plan[p]);
		end
		settle_products();
	endtask

	// Rewrites only three diagonal entries so the next product mixes new and
	// kept values: row 1 saturates low, row 2 shows the fraction shift
	// rounding toward minus infinity, and the corner saturates high.
	task automatic test_partial_rewrite();
		max_gap = 3;
		send_element_pair(IDX_W'(DIM + 1), Q_MAX, Q_MIN);
		send_element_pair(IDX_W'(2 * (DIM + 1)), 1, -1);
		send_element_pair(TRIGGER_POS, Q_MIN, Q_MIN);
		settle_products();
	endtask

	// Random traffic. Most groups are whole reloads in shuffled order ending
	// with the trigger; others rewrite a few entries before triggering, and
	// some only write entries that a later product picks up.
	task automatic test_random_matrices();
		logic [IDX_W-1:0] order [CELLS - 1];
		logic [IDX_W-1:0] swap;
		int               kind;
		int               count;
		int               j;
		int               stop_at;
		stop_at = beats_sent + RANDOM_BEATS;
		while (beats_sent < stop_at) begin
			max_gap     = ($urandom_range(0, 3) == 0) ? 0 : 3;
			wide_values = ($urandom_range(0, 2) == 0);
			kind        = $urandom_range(0, 19);
			for (int i = 0; i < CELLS - 1; i++)
				order[i] = IDX_W'(i);
			for (int i = CELLS - 2; i > 0; i--) begin
				j        = $urandom_range(0, i);
				swap     = order[i];
				order[i] = order[j];
				order[j] = swap;
			end
			if (kind < 12)
				count = CELLS - 1;
			else
				count = $urandom_range(1, 6);
			for (int i = 0; i < count; i++)
				send_element_pair(order[i], random_element(), random_element());
			if (kind < 17)
				send_element_pair(TRIGGER_POS, random_element(), random_element());
		end
		settle_products();
	endtask

	// Every result beat must match the oldest predicted element. Outputs are
	// read at the edge that ends their cycle, before any update of that edge.
	always @(posedge clk) begin : check_products
		product_beat_t want;
		if (arst_n && result_valid) begin
			if (expected_products.size() == 0) begin
				$display("%0t: result beat with nothing expected: element %0d index %0d last %0b",
					$time, product_element, product_index, last_of_matrix);
				mismatch_count++;
			end else begin
				want = expected_products.pop_front();
				if (product_element !== want.element) begin
					$display("%0t: product_element expected %0d actual %0d",
						$time, want.element, product_element);
					mismatch_count++;
				end
				if (product_index !== want.index) begin
					$display("%0t: product_index expected %0d actual %0d",
						$time, want.index, product_index);
					mismatch_count++;
				end
				if (last_of_matrix !== want.last) begin
					$display("%0t: last_of_matrix expected %0b actual %0b",
						$time, want.last, last_of_matrix);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog against a block that stops answering.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("matrix_multiply_4x4 verification failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// The first test writes every position, so no product ever reads an
		// entry that was never written.
		test_identity_with_extremes();
		test_partial_rewrite();
		test_random_matrices();
		if (mismatch_count == 0)
			$display("matrix_multiply_4x4 verification clean");
		else
			$display("matrix_multiply_4x4 verification failed");
		$finish;
	end

endmodule
